[rtl/aosc_pkg.sv]
// Package for the all-ones submatrix counter: fixed field widths, saturation
// limit, sequencer state type and the control/status words between modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package aosc_pkg;

  localparam int CFG_W = 9;
  localparam int TOTAL_W = 31;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 31'h7FFF_FFFF;
  localparam logic [CFG_W-1:0] WIDTH_RESET = 9'd8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_POP,
    ST_WAIT,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } aosc_state_t;

  // Sequencer strobes to the datapath
  typedef struct packed {
    logic clr_step;
    logic take;
    logic load_h;
    logic pop;
    logic mul;
    logic acc;
    logic emit;
  } aosc_ctl_t;

  // Datapath conditions back to the sequencer
  typedef struct packed {
    logic clr_done;
    logic pop_hit;
    logic last_item;
    logic out_free;
  } aosc_stat_t;

endpackage

`default_nettype wire

[rtl/aosc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module aosc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic [WIDTH-1:0]      wdata,
  input  wire logic [AW-1:0]         raddr,
  output logic      [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

[rtl/aosc_ctrl.sv]
// Sequencer of the all-ones submatrix counter: walks each pixel word through
// load, stack pops, multiply and accumulate, emits the result word, and runs the height clearing pass.
// Depends on aosc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module aosc_ctrl
  import aosc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire aosc_stat_t stat,
  output aosc_ctl_t       ctl
);

  aosc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (stat.clr_done) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_POP;
      ST_POP:   state_nxt = stat.pop_hit ? ST_WAIT : ST_MUL;
      ST_WAIT:  state_nxt = ST_POP;
      ST_MUL:   state_nxt = ST_ACC;
      ST_ACC:   state_nxt = stat.last_item ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (stat.out_free) state_nxt = ST_CLEAR;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    ctl = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR: ctl.clr_step = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.take = in_valid;
      end
      ST_LOAD:  ctl.load_h = 1'b1;
      ST_POP:   ctl.pop = stat.pop_hit;
      ST_WAIT:  ctl = '0;
      ST_MUL:   ctl.mul = 1'b1;
      ST_ACC:   ctl.acc = 1'b1;
      ST_EMIT:  ctl.emit = stat.out_free;
      default:  ctl = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/aosc_dpath.sv]
// Datapath of the all-ones submatrix counter: column height RAM, stack RAM with
// a registered top entry, one shared multiplier, saturating total, result word.
// Depends on aosc_pkg and aosc_ram.
`timescale 1ns / 1ps
`default_nettype none

module aosc_dpath
  import aosc_pkg::*;
#(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [CFG_W-1:0]   image_width,
  input  wire logic               pixel,
  input  wire logic               last_pixel,
  input  wire aosc_ctl_t          ctl,
  output aosc_stat_t              stat,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [TOTAL_W-1:0]      out_count
);

  localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int HW = $clog2(MAX_ROWS + 1);
  localparam int DW = (MAX_COLS > 1) ? $clog2(MAX_COLS + 1) : 1;
  localparam int SW = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int PW = HW + CW + 1;
  localparam int AW = (PW > SW) ? PW + 1 : SW + 1;
  localparam int EW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int NW = CW + HW + SW;

  logic              px_r, last_r;
  logic [CW-1:0]     col_r, clr_r, hwm_r;
  logic [DW-1:0]     depth_r;
  logic [HW-1:0]     h_r;
  logic [PW-1:0]     prod_r;
  logic [TOTAL_W-1:0] total_r;
  logic [CW-1:0]     top_col_r;
  logic [HW-1:0]     top_h_r;
  logic [SW-1:0]     top_sum_r;
  logic              out_valid_r;
  logic [TOTAL_W-1:0] out_count_r;

  logic [HW-1:0]     hgt_rd, hgt_wdata, h_nxt;
  logic [CW-1:0]     hgt_waddr;
  logic              hgt_we;
  logic [NW-1:0]     stk_rd, stk_wdata;
  logic [DW-1:0]     stk_rd_idx, stk_wr_idx;
  logic              stk_we;

  logic [EW-1:0]     width_ext, eff_width, col_inc;
  logic [CW-1:0]     col_nxt;
  logic [CW:0]       diff;
  logic [SW-1:0]     base_sum, s_val;
  logic [AW-1:0]     s_wide;
  logic [TOTAL_W:0]  total_sum;
  logic [TOTAL_W-1:0] total_nxt;

  // Height of the current column, saturating at MAX_ROWS
  always_comb begin
    if (!px_r) begin
      h_nxt = '0;
    end else if (hgt_rd < HW'(MAX_ROWS)) begin
      h_nxt = hgt_rd + HW'(1);
    end else begin
      h_nxt = HW'(MAX_ROWS);
    end
  end

  assign hgt_we    = ctl.clr_step | ctl.load_h;
  assign hgt_waddr = ctl.clr_step ? clr_r : col_r;
  assign hgt_wdata = ctl.clr_step ? '0 : h_nxt;

  aosc_ram #(.WIDTH(HW), .DEPTH(MAX_COLS)) u_hgt_ram (
    .clk   (clk),
    .we    (hgt_we),
    .waddr (hgt_waddr),
    .wdata (hgt_wdata),
    .raddr (col_r),
    .rdata (hgt_rd)
  );

  // Stack RAM holds every entry below the top one; the top lives in registers
  assign stk_rd_idx = depth_r - DW'(2);
  assign stk_wr_idx = depth_r - DW'(1);
  assign stk_we     = ctl.acc & (depth_r != '0);
  assign stk_wdata  = {top_col_r, top_h_r, top_sum_r};

  aosc_ram #(.WIDTH(NW), .DEPTH(MAX_COLS)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_wr_idx[CW-1:0]),
    .wdata (stk_wdata),
    .raddr (stk_rd_idx[CW-1:0]),
    .rdata (stk_rd)
  );

  // Effective row width: zero reads as one, clamp at MAX_COLS
  always_comb begin
    width_ext = EW'(image_width);
    if (width_ext == '0) begin
      eff_width = EW'(1);
    end else if (width_ext > EW'(MAX_COLS)) begin
      eff_width = EW'(MAX_COLS);
    end else begin
      eff_width = width_ext;
    end
    col_inc = EW'(col_r) + EW'(1);
    col_nxt = (col_inc >= eff_width) ? '0 : col_inc[CW-1:0];
  end

  // Span back to the previous smaller column, or to the row start
  assign diff = (depth_r == '0) ? ({1'b0, col_r} + (CW+1)'(1))
                                : ({1'b0, col_r} - {1'b0, top_col_r});

  assign base_sum  = (depth_r == '0) ? '0 : top_sum_r;
  assign s_wide    = AW'(base_sum) + AW'(prod_r);
  assign s_val     = s_wide[SW-1:0];
  assign total_sum = {1'b0, total_r} + (TOTAL_W+1)'(s_val);
  assign total_nxt = (total_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : total_sum[TOTAL_W-1:0];

  assign stat.clr_done  = (clr_r == hwm_r);
  assign stat.pop_hit   = (depth_r != '0) && (top_h_r >= h_r);
  assign stat.last_item = last_r;
  assign stat.out_free  = ~out_valid_r | out_ready;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      clr_r       <= '0;
      hwm_r       <= CW'(MAX_COLS - 1);
      depth_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.clr_step) begin
        clr_r <= clr_r + CW'(1);
        if (clr_r == hwm_r) begin
          hwm_r <= '0;
        end
      end
      if (ctl.load_h && col_r == '0) begin
        depth_r <= '0;
      end
      if (ctl.pop) begin
        depth_r <= depth_r - DW'(1);
      end
      if (ctl.acc) begin
        depth_r <= depth_r + DW'(1);
        total_r <= total_nxt;
        col_r   <= col_nxt;
        if (col_r > hwm_r) begin
          hwm_r <= col_r;
        end
      end
      if (ctl.emit) begin
        out_valid_r <= 1'b1;
        total_r     <= '0;
        col_r       <= '0;
        depth_r     <= '0;
        clr_r       <= '0;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      px_r   <= pixel;
      last_r <= last_pixel;
    end
    if (ctl.load_h) begin
      h_r <= h_nxt;
    end
    if (ctl.pop) begin
      {top_col_r, top_h_r, top_sum_r} <= stk_rd;
    end
    if (ctl.mul) begin
      prod_r <= PW'(h_r) * PW'(diff);
    end
    if (ctl.acc) begin
      top_col_r <= col_r;
      top_h_r   <= h_r;
      top_sum_r <= s_val;
    end
    if (ctl.emit) begin
      out_count_r <= total_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_count = out_count_r;

endmodule

`default_nettype wire

[rtl/all_ones_submatrix_counter_unit.sv]
// Top level of the all-ones submatrix counter: width register, sequencer and
// datapath. Depends on aosc_pkg, aosc_ctrl, aosc_dpath (and aosc_ram below it).
//
//   channel | direction | word                         | handshake
//   --------+-----------+------------------------------+-----------------------
//   cfg     | in        | cfg_image_width (9 bits)     | cfg_valid / cfg_ready
//   in      | in        | in_pixel, in_last_pixel      | in_valid / in_ready
//   out     | out       | out_submatrix_count (31 bits)| out_valid / out_ready
//
// One pixel word runs ST_LOAD, ST_POP, then ST_WAIT and ST_POP again for each
// stack entry it pops, then ST_MUL and ST_ACC before ready returns; the pop loop
// needs ST_WAIT because the stack RAM read is registered. Each word pushes one
// entry, so pops are bounded by pushes.
// A last-pixel word adds the ST_EMIT state to load the result word, then a clearing
// pass over the height RAM, one column per cycle up to the highest column used.
// After reset the pass covers all MAX_COLS columns before in_ready rises.
// A waiting result does not block input; only the next last-pixel word waits
// for the result slot to drain.
`timescale 1ns / 1ps
`default_nettype none

module all_ones_submatrix_counter_unit
  import aosc_pkg::*;
#(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // configuration write channel
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CFG_W-1:0]    cfg_image_width,
  // pixel input channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_pixel,
  input  wire logic                in_last_pixel,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [TOTAL_W-1:0]       out_submatrix_count
);

  logic [CFG_W-1:0] width_r;
  aosc_ctl_t        ctl;
  aosc_stat_t       stat;

  // Width register: always open for writes, only changed while idle by contract
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
    end else if (cfg_valid) begin
      width_r <= cfg_image_width;
    end
  end

  // Sequencer: one pixel at a time through the shared multiplier and stack
  aosc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  // Datapath: heights, stack, multiply, saturating total, result register
  aosc_dpath #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .image_width (width_r),
    .pixel       (in_pixel),
    .last_pixel  (in_last_pixel),
    .ctl         (ctl),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_count   (out_submatrix_count)
  );

endmodule

`default_nettype wire

[rtl/aosc_checker.sv]
// Port-level checks for the all-ones submatrix counter, bound to its top level.
// Depends on aosc_pkg and all_ones_submatrix_counter_unit.
`timescale 1ns / 1ps
`default_nettype none

module aosc_checker
  import aosc_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [TOTAL_W-1:0] out_submatrix_count
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_submatrix_count))
    else $error("result word changed or dropped while stalled");

  // Drop ready after every accepted pixel word
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("pixel accepted while previous one still in work");

  // Clearing pass follows reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input ready right after reset");

  // A new result appears only while input is closed, and the clear pass follows
  a_emit_closed: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_ready && $past(!in_ready))
    else $error("result raised while input open");

endmodule

bind all_ones_submatrix_counter_unit aosc_checker u_aosc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_submatrix_count (out_submatrix_count)
);

`default_nettype wire
